// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

	localparam int unsigned JSU_QDEPTH = 4;
	localparam int unsigned CP_W = 21;

	typedef enum logic [2:0] {
		ST_BUSY      = 3'd0,
		ST_DONE      = 3'd1,
		ST_NO_CLOSE  = 3'd2,
		ST_BAD_ESC   = 3'd3,
		ST_CTRL      = 3'd4,
		ST_BAD_HEX   = 3'd5,
		ST_BAD_SURR  = 3'd6,
		ST_NO_OPEN   = 3'd7
	} status_t;

	// One decoded item: a code point to encode (when has is set) and a status.
	// raw marks a plain string byte that goes out as is, without UTF-8 encoding.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            raw;
		logic            has;
		status_t         status;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/jsu_front.sv =====
// Front end: escape state machine, turns each input byte into one job.
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_end,
	input  logic          q_ready,
	output logic          q_push,
	output jsu_pkg::job_t q_job
);
	import jsu_pkg::*;

	typedef enum logic [6:0] {
		M_IDLE = 7'b0000001,
		M_STR  = 7'b0000010,
		M_ESC  = 7'b0000100,
		M_HEX1 = 7'b0001000,
		M_SBS  = 7'b0010000,
		M_SU   = 7'b0100000,
		M_HEX2 = 7'b1000000
	} mode_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	mode_t       mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  hs_q, hs_d;
	logic [4:0]  hex;
	logic [15:0] acc_nxt;
	status_t     st;
	logic        emit;
	logic        raw;
	logic [CP_W-1:0] cp;

	// {ok, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	assign hex = hex_digit(in_byte);
	assign acc_nxt = {acc_q[11:0], hex[3:0]};

	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		acc_d  = acc_q;
		hs_d   = hs_q;
		st     = ST_BUSY;
		emit   = 1'b0;
		raw    = 1'b0;
		cp     = '0;
		unique case (mode_q)
			M_IDLE: begin
				if (!in_end && in_byte == CH_QUOTE) mode_d = M_STR;
				else st = ST_NO_OPEN;
			end
			M_STR: begin
				if (in_end) st = ST_NO_CLOSE;
				else if (in_byte == CH_QUOTE) st = ST_DONE;
				else if (in_byte == CH_BSLASH) mode_d = M_ESC;
				else if (in_byte < CH_SPACE) st = ST_CTRL;
				else begin
					emit = 1'b1;
					raw  = 1'b1;
					cp = {{(CP_W-8){1'b0}}, in_byte};
				end
			end
			M_ESC: begin
				mode_d = M_STR;
				if (in_end) begin
					st = ST_BAD_ESC;
				end else begin
					emit = 1'b1;
					unique case (in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: cp = {{(CP_W-8){1'b0}}, in_byte};
						CH_B: cp = 21'h08;
						CH_F: cp = 21'h0C;
						CH_N: cp = 21'h0A;
						CH_R: cp = 21'h0D;
						CH_T: cp = 21'h09;
						CH_U: begin
							emit   = 1'b0;
							mode_d = M_HEX1;
							cnt_d  = '0;
							acc_d  = '0;
						end
						default: begin
							emit = 1'b0;
							st   = ST_BAD_ESC;
						end
					endcase
				end
			end
			M_HEX1, M_HEX2: begin
				if (in_end || !hex[4]) begin
					st = ST_BAD_HEX;
				end else begin
					acc_d = acc_nxt;
					if (cnt_q != 2'd3) begin
						cnt_d = cnt_q + 2'd1;
					end else begin
						cnt_d = '0;
						if (mode_q == M_HEX1) begin
							if (acc_nxt[15:10] == HI_SURR_TAG) begin
								hs_d   = acc_nxt[9:0];
								mode_d = M_SBS;
							end else begin
								emit   = 1'b1;
								cp     = {{(CP_W-16){1'b0}}, acc_nxt};
								mode_d = M_STR;
							end
						end else if (acc_nxt[15:10] != LO_SURR_TAG) begin
							st = ST_BAD_SURR;
						end else begin
							emit   = 1'b1;
							cp     = {1'b0, hs_q, acc_nxt[9:0]} + SUPP_BASE;
							mode_d = M_STR;
						end
					end
				end
			end
			M_SBS: begin
				if (in_end || in_byte != CH_BSLASH) st = ST_BAD_SURR;
				else mode_d = M_SU;
			end
			M_SU: begin
				if (in_end || in_byte != CH_U) begin
					st = ST_BAD_SURR;
				end else begin
					mode_d = M_HEX2;
					cnt_d  = '0;
					acc_d  = '0;
				end
			end
			default: begin
				mode_d = M_IDLE;
				st     = ST_NO_OPEN;
			end
		endcase
		if (st != ST_BUSY) begin
			mode_d = M_IDLE;
			cnt_d  = '0;
		end
	end

	assign q_push = in_valid && q_ready;
	assign q_job  = '{cp: cp, raw: raw, has: emit, status: st};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cnt_q  <= '0;
			acc_q  <= '0;
			hs_q   <= '0;
		end else if (q_push) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			hs_q   <= hs_d;
		end
	end

	// any ending status sends the machine back to wait for a quote
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_job.status != ST_BUSY |=> mode_q == M_IDLE && cnt_q == 2'd0)
		else $error("front not idle after ending status");
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_job.has |-> q_job.status == ST_BUSY)
		else $error("byte job with ending status");
	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_job.has |-> q_job.cp <= 21'h10FFFF)
		else $error("code point out of range");
endmodule

// ===== rtl/jsu_queue.sv =====
// Small job FIFO between the front end and the UTF-8 encoder.
module jsu_queue #(
	parameter int unsigned DEPTH = jsu_pkg::JSU_QDEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::job_t    push_job,
	input  logic             pop,
	output jsu_pkg::job_t    head,
	output jsu_pkg::q_stat_t stat
);
	import jsu_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count past depth");
endmodule

// ===== rtl/jsu_back.sv =====
// Back end: encodes each job into one to four result items behind an output register.
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_pkg::job_t    head,
	input  jsu_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_has,
	output jsu_pkg::status_t out_status,
	output logic             out_last
);
	import jsu_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       has_q;
	status_t    status_q;
	logic       last_q;
	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic [7:0] enc [4];
	logic       load;
	logic       is_last;

	always_comb begin
		priority if (!head.has || head.raw) last_idx = 2'd0;
		else if (head.cp[CP_W-1:7] == '0) last_idx = 2'd0;
		else if (head.cp[CP_W-1:11] == '0) last_idx = 2'd1;
		else if (head.cp[CP_W-1:16] == '0) last_idx = 2'd2;
		else last_idx = 2'd3;
	end

	always_comb begin
		enc[0] = '0;
		enc[1] = '0;
		enc[2] = '0;
		enc[3] = '0;
		unique case (last_idx)
			2'd0: enc[0] = head.has ? head.cp[7:0] : 8'h00;
			2'd1: begin
				enc[0] = {3'b110, head.cp[10:6]};
				enc[1] = {2'b10, head.cp[5:0]};
			end
			2'd2: begin
				enc[0] = {4'b1110, head.cp[15:12]};
				enc[1] = {2'b10, head.cp[11:6]};
				enc[2] = {2'b10, head.cp[5:0]};
			end
			2'd3: begin
				enc[0] = {5'b11110, head.cp[20:18]};
				enc[1] = {2'b10, head.cp[17:12]};
				enc[2] = {2'b10, head.cp[11:6]};
				enc[3] = {2'b10, head.cp[5:0]};
			end
			default: enc[0] = '0;
		endcase
	end

	assign load    = !valid_q || out_ready;
	assign is_last = (idx_q == last_idx);
	assign pop     = load && !q_stat.empty && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !q_stat.empty;
			if (!q_stat.empty) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			byte_q   <= enc[idx_q];
			has_q    <= head.has;
			status_q <= head.has ? ST_BUSY : head.status;
			last_q   <= is_last;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign out_has    = has_q;
	assign out_status = status_q;
	assign out_last   = last_q;

	// mid-job index only while the job is still at the head
	a_idx_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> !q_stat.empty)
		else $error("partial job without head");
	a_nobyte_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !has_q |-> last_q)
		else $error("status item not last");
	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && has_q |-> status_q == ST_BUSY)
		else $error("byte item with ending status");
endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// Usage:
//   Input stream s_*: one text byte per item in s_tdata[7:0]; s_tlast=1 marks
//   the end of the text (the byte is then ignored). Start with the opening quote.
//   Output stream m_*: one result item per ready cycle. m_tdata[7:0] is the decoded
//   byte, m_tuser[0] says it is valid, m_tuser[3:1] is the status (0 busy,
//   1 done, 2..7 errors). m_tlast marks the final item caused by an input byte.
//   Each byte gives one item, the last digit of a \uXXXX one to three, of a pair four.
// Timing:
//   The front end decodes one byte per cycle into a job queue of QDEPTH entries
//   while s_tready is high; the encoder drains one result item per cycle into the
//   output register while m_tready is high. A byte is written to the queue, then
//   its first result to the output register. Sustained rate is one input byte per
//   cycle while each gives one item and m_tready is high; a byte that gives k items
//   holds the encoder until all are out. s_tready drops only when the job queue is full.
// Reset: arst_n clears the decoder to wait for an opening quote and empties
//   the queue and output register. When m_tready is low the output item holds
//   and the queue fills, then s_tready falls.
module json_string_unescape_utf8 #(
	parameter int unsigned QDEPTH = jsu_pkg::JSU_QDEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // text_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [3:0] m_tuser,   // [0] has_byte, [3:1] status
	output logic       m_tlast    // last
);
	import jsu_pkg::*;

	job_t    push_job, head;
	q_stat_t q_stat;
	logic    push, pop;
	logic    out_has;
	status_t out_status;

	assign s_tready = !q_stat.full;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_end   (s_tlast),
		.q_ready  (s_tready),
		.q_push   (push),
		.q_job    (push_job)
	);

	jsu_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_has    (out_has),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tuser = {out_status, out_has};
endmodule

// ===== tb/tb_json_string_unescape_utf8.sv =====
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
	import jsu_pkg::*;

	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned TEXT_ITEMS = 440;
	localparam int unsigned TAIL_CYCLES = 20;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_STR, MODE_ESC, MODE_HEX1, MODE_SBS, MODE_SU, MODE_HEX2
	} unesc_mode_t;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_STALL} rx_mode_t;

	typedef struct packed {
		logic [7:0] ob;
		logic       has;
		status_t    st;
		logic       lst;
	} utf8_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       tend;
		logic       drain;   // hold this item until all decoded output is back
	} text_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
	logic       s_tlast = 1'b0;    // text_end
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_byte
	logic [3:0] m_tuser;           // [0] has_byte, [3:1] status
	logic       m_tlast;           // last

	json_string_unescape_utf8 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// decoder state mirror
	unesc_mode_t umode = MODE_IDLE;
	logic [1:0]  hex_cnt = 2'd0;
	logic [15:0] hex_acc = 16'h0000;
	logic [15:0] hi_surr = 16'h0000;

	text_item_t  text_queue[$];
	utf8_res_t   pending_utf8[$];
	int unsigned pushed_n = 0;
	int unsigned errors = 0;
	int unsigned idle_cyc = 0;

	logic [7:0]  esc_chars [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
	logic [15:0] cp_edges [10] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
		16'hD7FF, 16'hDC00, 16'hDFFF, 16'hE000, 16'hFFFF};

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + nib;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
	endfunction

	// Advance the mirror by one text item and queue the UTF-8 items it yields.
	task automatic unescape_byte(input logic [7:0] c, input logic tend);
		utf8_res_t   r [4];
		int          n;
		int          d;
		status_t     st;
		logic        emit;
		logic        raw;
		logic [20:0] cp;
		begin
			n = 0;
			st = ST_BUSY;
			emit = 1'b0;
			raw = 1'b0;
			cp = '0;
			for (int i = 0; i < 4; i++) r[i] = '0;
			case (umode)
				MODE_IDLE: begin
					if (!tend && c == CH_QUOTE) umode = MODE_STR;
					else st = ST_NO_OPEN;
				end
				MODE_STR: begin
					if (tend) st = ST_NO_CLOSE;
					else if (c == CH_QUOTE) st = ST_DONE;
					else if (c == CH_BSLASH) umode = MODE_ESC;
					else if (c < 8'h20) st = ST_CTRL;
					else begin
						// plain string bytes pass through unencoded
						cp = 21'(c);
						emit = 1'b1;
						raw = 1'b1;
					end
				end
				MODE_ESC: begin
					umode = MODE_STR;
					if (tend) st = ST_BAD_ESC;
					else begin
						emit = 1'b1;
						case (c)
							8'h22, 8'h5C, 8'h2F: cp = 21'(c);
							8'h62: cp = 21'h08;
							8'h66: cp = 21'h0C;
							8'h6E: cp = 21'h0A;
							8'h72: cp = 21'h0D;
							8'h74: cp = 21'h09;
							CH_U: begin
								emit = 1'b0;
								umode = MODE_HEX1;
								hex_cnt = 2'd0;
								hex_acc = 16'h0000;
							end
							default: begin
								emit = 1'b0;
								st = ST_BAD_ESC;
							end
						endcase
					end
				end
				MODE_HEX1, MODE_HEX2: begin
					d = tend ? -1 : hex_nibble(c);
					if (d < 0) st = ST_BAD_HEX;
					else begin
						hex_acc = {hex_acc[11:0], d[3:0]};
						if (hex_cnt < 2'd3) hex_cnt = hex_cnt + 2'd1;
						else begin
							hex_cnt = 2'd0;
							if (umode == MODE_HEX1) begin
								if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
									hi_surr = hex_acc;
									umode = MODE_SBS;
								end else begin
									cp = 21'(hex_acc);
									emit = 1'b1;
									umode = MODE_STR;
								end
							end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
								st = ST_BAD_SURR;
							end else begin
								cp = {1'b0, hi_surr[9:0], hex_acc[9:0]} + 21'h10000;
								emit = 1'b1;
								umode = MODE_STR;
							end
						end
					end
				end
				MODE_SBS: begin
					if (tend || c != CH_BSLASH) st = ST_BAD_SURR;
					else umode = MODE_SU;
				end
				MODE_SU: begin
					if (tend || c != CH_U) st = ST_BAD_SURR;
					else begin
						umode = MODE_HEX2;
						hex_cnt = 2'd0;
						hex_acc = 16'h0000;
					end
				end
				default: begin
					umode = MODE_IDLE;
					st = ST_NO_OPEN;
				end
			endcase
			if (st != ST_BUSY) begin
				umode = MODE_IDLE;
				hex_cnt = 2'd0;
			end
			if (emit) begin
				if (raw || cp <= 21'h7F) begin
					r[0].ob = cp[7:0];
					n = 1;
				end else if (cp <= 21'h7FF) begin
					r[0].ob = 8'hC0 | cp[10:6];
					r[1].ob = 8'h80 | cp[5:0];
					n = 2;
				end else if (cp <= 21'hFFFF) begin
					r[0].ob = 8'hE0 | cp[15:12];
					r[1].ob = 8'h80 | cp[11:6];
					r[2].ob = 8'h80 | cp[5:0];
					n = 3;
				end else begin
					r[0].ob = 8'hF0 | cp[20:18];
					r[1].ob = 8'h80 | cp[17:12];
					r[2].ob = 8'h80 | cp[11:6];
					r[3].ob = 8'h80 | cp[5:0];
					n = 4;
				end
				for (int i = 0; i < n; i++) begin
					r[i].has = 1'b1;
					r[i].st = ST_BUSY;
				end
			end
			if (n == 0) begin
				r[0].st = st;
				n = 1;
			end
			r[n-1].lst = 1'b1;
			for (int i = 0; i < n; i++) pending_utf8.insert(pending_utf8.size(), r[i]);
		end
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic push_byte(input logic [7:0] b, input logic tend = 1'b0,
		input logic drain = 1'b0);
		text_item_t t;
		begin
			t.b = b;
			t.tend = tend;
			t.drain = drain;
			text_queue.insert(text_queue.size(), t);
			pushed_n++;
		end
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	task automatic push_uescape(input logic [15:0] v);
		begin
			push_byte(CH_BSLASH);
			push_byte(CH_U);
			for (int i = 3; i >= 0; i--) push_byte(hex_char(v[i*4 +: 4]));
		end
	endtask

	// One string: mostly well formed, sometimes cut short by an error.
	task automatic gen_string(input logic drain);
		int          ntok;
		int          kind;
		int          k;
		logic [7:0]  b;
		logic [15:0] v;
		begin
			push_byte(CH_QUOTE, 1'b0, drain);
			ntok = $urandom_range(0, 6);
			for (int i = 0; i < ntok; i++) begin
				kind = $urandom_range(0, 9);
				if (kind <= 3) begin
					b = 8'($urandom_range(8'h20, 8'hFF));
					if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
					push_byte(b);
				end else if (kind <= 5) begin
					push_byte(CH_BSLASH);
					push_byte(esc_chars[$urandom_range(0, 7)]);
				end else if (kind <= 7) begin
					v = $urandom_range(0, 1) ? cp_edges[$urandom_range(0, 9)] : 16'($urandom);
					// keep it out of the high-surrogate range; lands on a lone low one
					if (v >= 16'hD800 && v <= 16'hDBFF) v[10] = 1'b1;
					push_uescape(v);
				end else begin
					push_uescape(16'hD800 | 16'($urandom_range(0, 1023)));
					push_uescape(16'hDC00 | 16'($urandom_range(0, 1023)));
				end
			end
			kind = $urandom_range(0, 15);
			case (kind)
				11: push_byte(8'($urandom), 1'b1);
				12: push_byte(8'($urandom_range(0, 31)));
				13: begin
					push_byte(CH_BSLASH);
					if ($urandom_range(0, 3) == 0) push_byte(8'($urandom), 1'b1);
					else begin
						b = 8'($urandom);
						case (b)
							8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, CH_U:
								b = 8'h00;
							default: ;
						endcase
						push_byte(b);
					end
				end
				14: begin
					push_byte(CH_BSLASH);
					push_byte(CH_U);
					k = $urandom_range(0, 3);
					for (int i = 0; i < k; i++) push_byte(hex_char(4'($urandom)));
					b = 8'($urandom);
					if (hex_nibble(b) >= 0) b = 8'h47;
					push_byte(b, $urandom_range(0, 3) == 0);
				end
				15: begin
					push_uescape(16'hD800 | 16'($urandom_range(0, 1023)));
					case ($urandom_range(0, 3))
						0: begin
							b = 8'($urandom);
							if (b == CH_BSLASH) b = 8'h5D;
							push_byte(b);
						end
						1: begin
							push_byte(CH_BSLASH);
							b = 8'($urandom);
							if (b == CH_U) b = 8'h55;
							push_byte(b, $urandom_range(0, 2) == 0);
						end
						2: push_byte(8'($urandom), 1'b1);
						default: begin
							v = 16'($urandom);
							if (v[15:10] == 6'b110111) v[13] = 1'b0;
							push_uescape(v);
						end
					endcase
				end
				default: push_byte(CH_QUOTE);
			endcase
			// stray bytes between strings
			if ($urandom_range(0, 7) == 0) begin
				b = 8'($urandom);
				if (b == CH_QUOTE) b = 8'h23;
				push_byte(b, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// ---------------- sender ----------------

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : sender
		text_item_t t;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) unescape_byte(s_tdata, s_tlast);
			if (s_tvalid && !s_tready) begin
				// hold the item until taken
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (text_queue.size() == 0 ||
				(text_queue[0].drain && pending_utf8.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				t = text_queue.pop_front();
				s_tdata <= t.b;
				s_tlast <= t.tend;
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// ---------------- receiver ----------------

	rx_mode_t   rx_mode = RX_FREE;
	logic [7:0] rx_cyc = 8'd0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode <= RX_FREE;
			rx_cyc <= 8'd0;
		end else begin
			rx_cyc <= rx_cyc + 8'd1;
			if (rx_cyc[6:0] == 7'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_FREE:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= (rx_cyc[1:0] == 2'd3);
				default:   m_tready <= (rx_cyc[4:0] >= 5'd20);
			endcase
		end
	end

	// ---------------- monitor and activity counter ----------------

	always @(posedge clk) begin : monitor
		utf8_res_t e;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc <= 0;
			else idle_cyc <= idle_cyc + 1;
			if (m_tvalid && m_tready) begin
				if (pending_utf8.size() == 0) begin
					$error("unexpected item: out_byte %h has_byte %b status %0d last %b",
						m_tdata, m_tuser[0], m_tuser[3:1], m_tlast);
					errors++;
				end else begin
					e = pending_utf8.pop_front();
					if (m_tdata !== e.ob) begin
						$error("out_byte: expected %h, got %h", e.ob, m_tdata);
						errors++;
					end
					if (m_tuser[0] !== e.has) begin
						$error("has_byte: expected %b, got %b", e.has, m_tuser[0]);
						errors++;
					end
					if (m_tuser[3:1] !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, m_tuser[3:1]);
						errors++;
					end
					if (m_tlast !== e.lst) begin
						$error("last: expected %b, got %b", e.lst, m_tlast);
						errors++;
					end
				end
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int unsigned directed_n;
		int unsigned strings_n;
		// no opening quote, then text end while idle
		push_byte(8'hFF);
		push_byte(8'hFF, 1'b1);
		// raw NUL inside a string
		push_byte(CH_QUOTE);
		push_byte(8'h00);
		// text end right after a backslash
		push_text("\"\\");
		push_byte(8'h00, 1'b1);
		// non-hex digit in a \u escape
		push_text("\"\\ug");
		// highest code point through a surrogate pair, mixed case hex
		push_text("\"\\udbFF\\uDfff\"");
		directed_n = pushed_n;
		strings_n = 0;
		while (pushed_n < directed_n + TEXT_ITEMS) begin
			gen_string(strings_n == 0 || $urandom_range(0, 29) == 0);
			strings_n++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while ((text_queue.size() != 0 || s_tvalid || pending_utf8.size() != 0) &&
			idle_cyc < IDLE_LIMIT && errors == 0)
			@(negedge clk);
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("json_string_unescape_utf8 verification failed");
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			if (errors == 0 && pending_utf8.size() == 0)
				$display("json_string_unescape_utf8 verification clean");
			else
				$display("json_string_unescape_utf8 verification failed");
		end
		$finish;
	end

endmodule

// ===== json_string_unescape_utf8.f =====
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/tb_json_string_unescape_utf8.sv
